/* hw/rtl/ir_pulse_width_command_decoder_top_macros.svh */
// ============================================================================
// IR pulse-width decoder assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and disabled in reset.
// ============================================================================
`ifndef IR_PULSE_WIDTH_COMMAND_DECODER_TOP_MACROS_SVH
`define IR_PULSE_WIDTH_COMMAND_DECODER_TOP_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define IPWD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// An implication checked in the same cycle.
`define IPWD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// An implication whose consequent is checked in the next cycle.
`define IPWD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/ipwd_pkg.sv */
// ============================================================================
// IR pulse-width decoder package
// Types and fixed constants shared by the decoder modules.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package ipwd_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_START_LEN   = 3'd0,
    CFG_MIN_LEN     = 3'd1,
    CFG_SHORT_SPACE = 3'd2,
    CFG_SHORT_FILL  = 3'd3,
    CFG_LONG_SPACE  = 3'd4,
    CFG_LONG_FILL   = 3'd5,
    CFG_TOLERANCE   = 3'd6
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  // Register reset values.
  localparam logic [7:0] StartLenRst   = 8'd29;
  localparam logic [7:0] MinLenRst     = 8'd9;
  localparam logic [6:0] ShortSpaceRst = 7'd10;
  localparam logic [6:0] ShortFillRst  = 7'd17;
  localparam logic [6:0] LongSpaceRst  = 7'd23;
  localparam logic [6:0] LongFillRst   = 7'd30;
  localparam logic [6:0] ToleranceRst  = 7'd2;

  // Counter overflow point and repeat limit.
  localparam logic [7:0] CountMax    = 8'hFF;
  localparam logic [1:0] RepeatLimit = 2'd3;

  // Interval classes in priority order.
  typedef enum logic [2:0] {
    CLS_SHORT_SPACE = 3'd0,
    CLS_SHORT_FILL  = 3'd1,
    CLS_LONG_SPACE  = 3'd2,
    CLS_LONG_FILL   = 3'd3,
    CLS_NONE        = 3'd4
  } cls_e;

  // Nominal widths and matching tolerance.
  typedef struct packed {
    logic [6:0] short_space;
    logic [6:0] short_fill;
    logic [6:0] long_space;
    logic [6:0] long_fill;
    logic [6:0] tolerance;
  } widths_t;

  // One result item.
  typedef struct packed {
    logic       code_valid;
    logic [7:0] code_value;
    logic       is_recording;
    logic       idle_led;
    logic       frame_led;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/ipwd_in_if.sv */
// ============================================================================
// IR pulse-width decoder input channel
// Valid/ready channel carrying one sampled line level per request.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface ipwd_in_if;
  logic valid;
  logic ready;
  logic line_level;

  modport source (output valid, output line_level, input ready);
  modport sink   (input valid, input line_level, output ready);
endinterface

`default_nettype wire

/* hw/rtl/ipwd_out_if.sv */
// ============================================================================
// IR pulse-width decoder output channel
// Valid/ready channel carrying one decoder result per request.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface ipwd_out_if;
  logic       valid;
  logic       ready;
  logic       code_valid;
  logic [7:0] code_value;
  logic       is_recording;
  logic       idle_led;
  logic       frame_led;

  modport source (output valid, output code_valid, output code_value,
                  output is_recording, output idle_led, output frame_led,
                  input ready);
  modport sink   (input valid, input code_valid, input code_value,
                  input is_recording, input idle_led, input frame_led,
                  output ready);
endinterface

`default_nettype wire

/* hw/rtl/ipwd_classify.sv */
// ============================================================================
// IR pulse-width interval classifier
// Matches a 7-bit interval against four nominal widths within a tolerance.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ipwd_classify (
  input  logic [6:0]       interval_i,
  input  ipwd_pkg::widths_t widths_i,
  output ipwd_pkg::cls_e   cls_o
);
  import ipwd_pkg::*;

  logic near_ss, near_sf, near_ls, near_lf;

  function automatic logic near_width(input logic [6:0] t, input logic [6:0] nominal,
                                      input logic [6:0] tol);
    logic [6:0] diff;
    diff = (t > nominal) ? (t - nominal) : (nominal - t);
    return diff <= tol;
  endfunction

  // The four distance checks run side by side.
  assign near_ss = near_width(interval_i, widths_i.short_space, widths_i.tolerance);
  assign near_sf = near_width(interval_i, widths_i.short_fill, widths_i.tolerance);
  assign near_ls = near_width(interval_i, widths_i.long_space, widths_i.tolerance);
  assign near_lf = near_width(interval_i, widths_i.long_fill, widths_i.tolerance);

  // The first match in priority order wins.
  always_comb begin
    if (near_ss) begin
      cls_o = CLS_SHORT_SPACE;
    end else if (near_sf) begin
      cls_o = CLS_SHORT_FILL;
    end else if (near_ls) begin
      cls_o = CLS_LONG_SPACE;
    end else if (near_lf) begin
      cls_o = CLS_LONG_FILL;
    end else begin
      cls_o = CLS_NONE;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ipwd_out_buf.sv */
// ============================================================================
// IR pulse-width decoder output buffer
// Output register plus skid entry, so the ready path is fully registered.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ipwd_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              ready_o,
  input  ipwd_pkg::result_t data_i,
  output logic              valid_o,
  input  logic              pop_ready_i,
  output ipwd_pkg::result_t data_o
);
  import ipwd_pkg::*;

  logic    out_valid_d, out_valid_q;
  logic    skid_valid_d, skid_valid_q;
  result_t out_d, out_q;
  result_t skid_d, skid_q;
  logic    out_free;

  // New requests are taken whenever the skid entry is empty.
  assign ready_o  = !skid_valid_q;
  assign out_free = !out_valid_q || pop_ready_i;

  // Refill the output stage from the skid entry first, then from the input.
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push_i;
        out_d       = data_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_q;

endmodule

`default_nettype wire

/* hw/rtl/ir_pulse_width_command_decoder_top.sv */
// Each result is registered into the output register, or the skid entry if the output stalls.
// Throughput: one sample per cycle while the skid entry is free; the state update is a single registered pass.
// The output register and skid entry keep requests flowing while one result waits.
// Reset returns all decoder state to its reset values and loads the register defaults at once.
// No clearing pass: samples are taken from the first cycle after reset.
// ============================================================================
// IR pulse-width command decoder, top level
// Measures intervals between line edges, decodes frames into 8-bit command
// codes on the fly, and suppresses repeated codes.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

`include "ir_pulse_width_command_decoder_top_macros.svh"

module ir_pulse_width_command_decoder_top #(
  parameter int unsigned MAX_PULSES = 100
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ipwd_in_if.sink                       in_i,
  ipwd_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [ipwd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ipwd_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import ipwd_pkg::*;

  localparam int unsigned PidxW = $clog2(MAX_PULSES + 1);

  // Configuration registers.
  logic [7:0] start_len_q, min_len_q;
  widths_t    widths_q;

  // Decoder state.
  logic             prev_d, prev_q;
  logic [7:0]       cnt_d, cnt_q;
  logic             run_d, run_q;
  logic             rec_d, rec_q;
  logic [PidxW-1:0] pidx_d, pidx_q;
  logic [7:0]       word_d, word_q;
  logic             bit_d, bit_q;
  logic             stop_d, stop_q;
  logic [7:0]       last_d, last_q;
  logic [1:0]       rep_d, rep_q;
  logic             idle_led_d, idle_led_q;
  logic             frame_led_d, frame_led_q;

  logic       acc;
  logic       level;
  logic [7:0] interval;
  logic [1:0] rep_inc;
  cls_e       cls;
  result_t    res;
  result_t    buf_data;
  logic       buf_ready;

  assign acc      = in_i.valid && in_i.ready;
  assign level    = in_i.line_level;
  assign interval = run_q ? cnt_q : 8'd0;
  assign rep_inc  = rep_q + 2'd1;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_len_q          <= StartLenRst;
      min_len_q            <= MinLenRst;
      widths_q.short_space <= ShortSpaceRst;
      widths_q.short_fill  <= ShortFillRst;
      widths_q.long_space  <= LongSpaceRst;
      widths_q.long_fill   <= LongFillRst;
      widths_q.tolerance   <= ToleranceRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_LEN:   start_len_q          <= cfg_wdata_i;
        CFG_MIN_LEN:     min_len_q            <= cfg_wdata_i;
        CFG_SHORT_SPACE: widths_q.short_space <= cfg_wdata_i[6:0];
        CFG_SHORT_FILL:  widths_q.short_fill  <= cfg_wdata_i[6:0];
        CFG_LONG_SPACE:  widths_q.long_space  <= cfg_wdata_i[6:0];
        CFG_LONG_FILL:   widths_q.long_fill   <= cfg_wdata_i[6:0];
        CFG_TOLERANCE:   widths_q.tolerance   <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  // Interval classification on the low seven bits.
  ipwd_classify u_classify (
    .interval_i (interval[6:0]),
    .widths_i   (widths_q),
    .cls_o      (cls)
  );

  // Per-sample state update and result.
  always_comb begin
    prev_d         = level;
    cnt_d          = cnt_q;
    run_d          = run_q;
    rec_d          = rec_q;
    pidx_d         = pidx_q;
    word_d         = word_q;
    bit_d          = bit_q;
    stop_d         = stop_q;
    last_d         = last_q;
    rep_d          = rep_q;
    idle_led_d     = idle_led_q;
    frame_led_d    = frame_led_q;
    res.code_valid = 1'b0;
    res.code_value = 8'd0;

    if (level != prev_q) begin
      // Edge: restart the interval counter.
      cnt_d = 8'd0;
      run_d = 1'b1;
      if (rec_q) begin
        if (interval < min_len_q) begin
          rec_d = 1'b0;
        end else if (pidx_q < PidxW'(MAX_PULSES)) begin
          pidx_d = pidx_q + PidxW'(1);
          if (!stop_q) begin
            case (cls)
              CLS_SHORT_SPACE: word_d = {word_q[6:0], bit_q};
              CLS_SHORT_FILL:  ;
              CLS_LONG_SPACE: begin
                bit_d  = 1'b1;
                word_d = {word_q[6:0], 1'b1};
              end
              CLS_LONG_FILL: begin
                bit_d  = 1'b0;
                word_d = {word_q[6:0], 1'b0};
              end
              default: stop_d = 1'b1;
            endcase
          end
        end
      end else if (level) begin
        // Rising edge after a long enough gap opens a frame.
        if (interval > start_len_q) begin
          pidx_d      = PidxW'(1);
          word_d      = 8'd0;
          bit_d       = 1'b0;
          stop_d      = 1'b0;
          rec_d       = 1'b1;
          frame_led_d = 1'b1;
        end
        idle_led_d = 1'b0;
      end else begin
        idle_led_d  = 1'b1;
        frame_led_d = 1'b0;
      end
    end else if (run_q) begin
      if (cnt_q == CountMax) begin
        // Counter overflow: stop, and close any open frame.
        cnt_d = 8'd0;
        run_d = 1'b0;
        if (rec_q) begin
          rec_d = 1'b0;
          if (word_q[7]) begin
            if (word_q != last_q) begin
              last_d         = word_q;
              rep_d          = 2'd1;
              res.code_valid = 1'b1;
              res.code_value = word_q;
            end else if (rep_inc == RepeatLimit) begin
              rep_d  = 2'd0;
              last_d = 8'd0;
            end else begin
              rep_d = rep_inc;
            end
          end
        end
      end else begin
        cnt_d = cnt_q + 8'd1;
      end
    end

    res.is_recording = rec_d;
    res.idle_led     = idle_led_d;
    res.frame_led    = frame_led_d;
  end

  // State registers advance on each accepted request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= 1'b1;
      cnt_q       <= 8'd0;
      run_q       <= 1'b0;
      rec_q       <= 1'b0;
      pidx_q      <= '0;
      word_q      <= 8'd0;
      bit_q       <= 1'b0;
      stop_q      <= 1'b0;
      last_q      <= 8'd0;
      rep_q       <= 2'd0;
      idle_led_q  <= 1'b0;
      frame_led_q <= 1'b0;
    end else if (acc) begin
      prev_q      <= prev_d;
      cnt_q       <= cnt_d;
      run_q       <= run_d;
      rec_q       <= rec_d;
      pidx_q      <= pidx_d;
      word_q      <= word_d;
      bit_q       <= bit_d;
      stop_q      <= stop_d;
      last_q      <= last_d;
      rep_q       <= rep_d;
      idle_led_q  <= idle_led_d;
      frame_led_q <= frame_led_d;
    end
  end

  // Result register with skid entry.
  ipwd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (acc),
    .ready_o     (buf_ready),
    .data_i      (res),
    .valid_o     (out_o.valid),
    .pop_ready_i (out_o.ready),
    .data_o      (buf_data)
  );

  assign in_i.ready         = buf_ready;
  assign out_o.code_valid   = buf_data.code_valid;
  assign out_o.code_value   = buf_data.code_value;
  assign out_o.is_recording = buf_data.is_recording;
  assign out_o.idle_led     = buf_data.idle_led;
  assign out_o.frame_led    = buf_data.frame_led;

  // Assertions.
  `IPWD_ASSERT_IMPL(a_code_msb, acc && res.code_valid, res.code_value[7], "code without MSB")
  `IPWD_ASSERT_NEXT(a_emit_ends_frame, acc && res.code_valid, !rec_q, "frame open after code")
  `IPWD_ASSERT_IMPL(a_stopped_clear, !run_q, cnt_q == 8'd0, "stopped counter not clear")
  `IPWD_ASSERT_ALWAYS(a_pidx_range, pidx_q <= PidxW'(MAX_PULSES), "pulse index out of range")
  `IPWD_ASSERT_ALWAYS(a_rep_range, rep_q != RepeatLimit, "repeat count at limit")

endmodule

`default_nettype wire

/* verif/ipwd_code_checker.sv */
// ============================================================================
// IR pulse-width decoder result checker
// Watches the sample, result and register write ports of the decoder. It keeps
// its own model of the interval counter, the frame decoder and the repeat
// filter, queues the result due for every accepted sample, and compares each
// accepted result with the oldest one waiting.
// ============================================================================
`timescale 1ns / 1ps

module ipwd_code_checker #(
  parameter int unsigned MaxPulses = 100
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ipwd_in_if                            in_mon_i,
  ipwd_out_if                           out_mon_i,
  input  logic                          cfg_we_i,
  input  logic [ipwd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ipwd_pkg::CfgDataW-1:0] cfg_wdata_i,
  output int unsigned                   mismatches_o,
  output int unsigned                   pending_o
);
  import ipwd_pkg::*;

  // Register copies.
  logic [7:0] lead_gap;
  logic [7:0] min_len;
  widths_t    widths;

  // Decoder state.
  logic       prev_level;
  logic [7:0] ival_cnt;
  logic       cnt_run;
  logic       rec;
  logic [6:0] pulse_idx;
  logic [7:0] word;
  logic       cur_bit;
  logic       dec_stop;
  logic [7:0] last_word;
  logic [1:0] rpt_cnt;
  logic       idle_led;
  logic       frame_led;

  // Results due, oldest first.
  result_t decoder_reports_q [$];

  // One line per mismatch, and the count goes up.
  task automatic log_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches_o++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) begin
      log_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  function automatic logic width_near(input logic [6:0] t, input logic [6:0] nominal);
    logic [6:0] delta;
    delta = (t > nominal) ? t - nominal : nominal - t;
    return delta <= widths.tolerance;
  endfunction

  // Advances the decoder by one line sample and returns the result it reports.
  function automatic result_t decode_sample(input logic level);
    result_t    r;
    logic [7:0] t;
    r = '0;
    if (level != prev_level) begin
      // An edge measures the interval and restarts the counter.
      t        = cnt_run ? ival_cnt : 8'd0;
      ival_cnt = 8'd0;
      cnt_run  = 1'b1;
      if (rec) begin
        if (t < min_len) begin
          rec = 1'b0;
        end else if (pulse_idx < MaxPulses) begin
          pulse_idx = pulse_idx + 7'd1;
          if (!dec_stop) begin
            // Widths are tried in priority order.
            if (width_near(t[6:0], widths.short_space)) begin
              word = {word[6:0], cur_bit};
            end else if (width_near(t[6:0], widths.short_fill)) begin
              // Accepted filler, no effect on the word.
            end else if (width_near(t[6:0], widths.long_space)) begin
              cur_bit = 1'b1;
              word    = {word[6:0], 1'b1};
            end else if (width_near(t[6:0], widths.long_fill)) begin
              cur_bit = 1'b0;
              word    = {word[6:0], 1'b0};
            end else begin
              dec_stop = 1'b1;
            end
          end
        end
      end else if (level) begin
        if (t > lead_gap) begin
          pulse_idx = 7'd1;
          word      = 8'd0;
          cur_bit   = 1'b0;
          dec_stop  = 1'b0;
          rec       = 1'b1;
          frame_led = 1'b1;
        end
        idle_led = 1'b0;
      end else begin
        idle_led  = 1'b1;
        frame_led = 1'b0;
      end
    end else if (cnt_run) begin
      if (ival_cnt == CountMax) begin
        // Counter overflow stops the counter and closes an open frame.
        ival_cnt = 8'd0;
        cnt_run  = 1'b0;
        if (rec) begin
          rec = 1'b0;
          if (word[7]) begin
            if (word != last_word) begin
              last_word    = word;
              rpt_cnt      = 2'd1;
              r.code_valid = 1'b1;
              r.code_value = word;
            end else begin
              rpt_cnt = rpt_cnt + 2'd1;
              if (rpt_cnt == RepeatLimit) begin
                rpt_cnt   = 2'd0;
                last_word = 8'd0;
              end
            end
          end
        end
      end else begin
        ival_cnt = ival_cnt + 8'd1;
      end
    end
    prev_level     = level;
    r.is_recording = rec;
    r.idle_led     = idle_led;
    r.frame_led    = frame_led;
    return r;
  endfunction

  // Compare results, track register writes and predict on accepted samples.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      lead_gap                 = StartLenRst;
      min_len                  = MinLenRst;
      widths.short_space       = ShortSpaceRst;
      widths.short_fill        = ShortFillRst;
      widths.long_space        = LongSpaceRst;
      widths.long_fill         = LongFillRst;
      widths.tolerance         = ToleranceRst;
      prev_level               = 1'b1;
      ival_cnt                 = 8'd0;
      cnt_run                  = 1'b0;
      rec                      = 1'b0;
      pulse_idx                = 7'd0;
      word                     = 8'd0;
      cur_bit                  = 1'b0;
      dec_stop                 = 1'b0;
      last_word                = 8'd0;
      rpt_cnt                  = 2'd0;
      idle_led                 = 1'b0;
      frame_led                = 1'b0;
      decoder_reports_q.delete();
    end else begin
      if (out_mon_i.valid && out_mon_i.ready) begin
        got.code_valid   = out_mon_i.code_valid;
        got.code_value   = out_mon_i.code_value;
        got.is_recording = out_mon_i.is_recording;
        got.idle_led     = out_mon_i.idle_led;
        got.frame_led    = out_mon_i.frame_led;
        if (decoder_reports_q.size() == 0) begin
          log_mismatch("result request with no result due");
        end else begin
          want = decoder_reports_q.pop_front();
          check_field("code_valid", 8'(got.code_valid), 8'(want.code_valid));
          check_field("code_value", got.code_value, want.code_value);
          check_field("is_recording", 8'(got.is_recording), 8'(want.is_recording));
          check_field("idle_led", 8'(got.idle_led), 8'(want.idle_led));
          check_field("frame_led", 8'(got.frame_led), 8'(want.frame_led));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_START_LEN:   lead_gap           = cfg_wdata_i;
          CFG_MIN_LEN:     min_len            = cfg_wdata_i;
          CFG_SHORT_SPACE: widths.short_space = cfg_wdata_i[6:0];
          CFG_SHORT_FILL:  widths.short_fill  = cfg_wdata_i[6:0];
          CFG_LONG_SPACE:  widths.long_space  = cfg_wdata_i[6:0];
          CFG_LONG_FILL:   widths.long_fill   = cfg_wdata_i[6:0];
          CFG_TOLERANCE:   widths.tolerance   = cfg_wdata_i[6:0];
          default: ;
        endcase
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        decoder_reports_q.push_back(decode_sample(in_mon_i.line_level));
      end
    end
    pending_o = decoder_reports_q.size();
  end

endmodule

/* verif/testbench.sv */
// ============================================================================
// IR pulse-width decoder testbench
// Drives line samples shaped as remote-control frames (lead-in low period,
// coded intervals near the nominal widths, a closing overflow), plus replayed
// frames for repeat filtering and random line noise, under several register
// settings. Both channels stall at random; the checker beside the block
// predicts and compares every result.
// ============================================================================
`timescale 1ns / 1ps

module testbench;
  import ipwd_pkg::*;

  localparam int unsigned MaxPulses = 20;
  // Register index with no register behind it; writes to it must do nothing.
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 3'd7;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  int unsigned mismatches;
  int unsigned reports_pending;

  ipwd_in_if  in_ch ();
  ipwd_out_if out_ch ();

  // Stimulus bookkeeping.
  logic [7:0]  cfg_now [7];
  logic        line_now     = 1'b1;
  logic        calm         = 1'b0;
  logic        held_once    = 1'b0;
  int unsigned samples_sent = 0;
  int          last_frame [$];

  ir_pulse_width_command_decoder_top #(
    .MAX_PULSES (MaxPulses)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  ipwd_code_checker #(
    .MaxPulses (MaxPulses)
  ) code_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon_i     (in_ch),
    .out_mon_i    (out_ch),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .mismatches_o (mismatches),
    .pending_o    (reports_pending)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Offers one line sample and waits for its request to be taken.
  task automatic push_sample(input logic lvl);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.line_level <= lvl;
    do @(posedge clk_i); while (!in_ch.ready);
    line_now = lvl;
    samples_sent++;
  endtask

  task automatic emit_run(input logic lvl, input int n);
    for (int i = 0; i < n; i++) begin
      push_sample(lvl);
    end
  endtask

  // Stops offering and waits until every result has been taken.
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (reports_pending != 0);
    @(posedge clk_i);
  endtask

  // Writes all registers while the block is idle, plus the unused index.
  task automatic program_regs(input logic [7:0] lead_gap, min_len, short_space,
                              short_fill, long_space, long_fill, tol);
    logic junk_bit;
    cfg_now[CFG_START_LEN]   = lead_gap;
    cfg_now[CFG_MIN_LEN]     = min_len;
    cfg_now[CFG_SHORT_SPACE] = short_space;
    cfg_now[CFG_SHORT_FILL]  = short_fill;
    cfg_now[CFG_LONG_SPACE]  = long_space;
    cfg_now[CFG_LONG_FILL]   = long_fill;
    cfg_now[CFG_TOLERANCE]   = tol;
    settle();
    for (int i = 0; i < 7; i++) begin
      // The top bit of a 7-bit register is random: the block must ignore it.
      junk_bit  = $urandom_range(0, 1);
      cfg_we    <= 1'b1;
      cfg_idx   <= cfg_idx_e'(i);
      cfg_wdata <= (i >= CFG_SHORT_SPACE) ? {junk_bit, cfg_now[i][6:0]} : cfg_now[i];
      @(posedge clk_i);
    end
    cfg_idx   <= CfgIdxSpare;
    cfg_wdata <= 8'($urandom);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // One frame: a lead-in low period, then alternating segments, mostly near the
  // nominal widths and some random or below the minimum, then a closing run that
  // overflows the counter. A replay resends the last widths for repeat filtering.
  task automatic send_frame(input bit replay);
    int   t;
    int   sel;
    int   tol;
    logic lvl;
    if (!replay || last_frame.size() == 0) begin
      last_frame.delete();
      tol = cfg_now[CFG_TOLERANCE][6:0];
      repeat ($urandom_range(8, MaxPulses + 3)) begin
        sel = $urandom_range(0, 19);
        if (sel < 16) begin
          t = cfg_now[CFG_SHORT_SPACE + sel % 4][6:0];
          if ($urandom_range(0, 7) == 0) begin
            // Just outside the tolerance window.
            t = $urandom_range(0, 1) ? t + tol + 1 : t - tol - 1;
          end else begin
            t = t + int'($urandom_range(0, 2 * tol)) - tol;
          end
        end else if (sel < 19) begin
          t = $urandom_range(0, 255);
        end else begin
          t = $urandom_range(0, cfg_now[CFG_MIN_LEN]);
        end
        if (t < 0) t = 0;
        if (t > 255) t = 255;
        last_frame.push_back(t);
      end
    end
    if (line_now == 1'b0) begin
      emit_run(1'b1, $urandom_range(1, 3));
    end
    emit_run(1'b0, cfg_now[CFG_START_LEN] + 2 + $urandom_range(0, 3));
    lvl = 1'b1;
    foreach (last_frame[i]) begin
      emit_run(lvl, last_frame[i] + 1);
      lvl = !lvl;
    end
    emit_run(lvl, 257 + $urandom_range(0, 3));
  endtask

  // Random line activity, now and then long enough to overflow the counter.
  task automatic send_noise();
    repeat ($urandom_range(2, 8)) begin
      if ($urandom_range(0, 9) == 0) begin
        emit_run(!line_now, $urandom_range(257, 270));
      end else begin
        emit_run($urandom_range(0, 1), $urandom_range(1, 40));
      end
    end
  endtask

  // Result side: random stall bursts, one long hold-off that backs the block
  // up into its input, and no stalls once the run has calmed down.
  initial begin : result_sink
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held_once && samples_sent >= 300) begin
        held_once = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (50) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Sample side and verdict.
  initial begin : stimulus
    int phase;
    int nframes;
    int pick;
    in_ch.valid      <= 1'b0;
    in_ch.line_level <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_idx          <= CFG_START_LEN;
    cfg_wdata        <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: idle indicator on a falling edge, a short low period that
    // does not start a frame, a long one that does, one decoded interval,
    // then an interval below the minimum that aborts the frame.
    program_regs(8'd6, 8'd2, 8'd3, 8'd5, 8'd7, 8'd9, 8'd0);
    emit_run(1'b1, 2);
    emit_run(1'b0, 3);
    emit_run(1'b1, 2);
    emit_run(1'b0, 9);
    emit_run(1'b1, 4);
    emit_run(1'b0, 1);
    emit_run(1'b1, 1);

    // Random frames and noise under a rotation of register settings, until
    // the sample budget for this part is spent.
    phase = 1;
    while (samples_sent < 700) begin
      case (phase % 8)
        0: program_regs(StartLenRst, MinLenRst, {1'b0, ShortSpaceRst}, {1'b0, ShortFillRst},
                        {1'b0, LongSpaceRst}, {1'b0, LongFillRst}, {1'b0, ToleranceRst});
        2: program_regs(8'($urandom_range(2, 24)), 8'($urandom_range(0, 6)),
                        8'($urandom_range(1, 30)), 8'($urandom_range(1, 30)),
                        8'($urandom_range(1, 30)), 8'($urandom_range(1, 30)),
                        8'($urandom_range(0, 3)));
        4: program_regs(8'd8, 8'd3, 8'd6, 8'd6, 8'd8, 8'd11, 8'd2);
        5: program_regs(8'hFF, 8'hFF, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F);
        7: begin
          if ((phase / 8) % 2 == 0) begin
            program_regs(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
          end else begin
            program_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom), 8'($urandom));
          end
        end
        default: program_regs(8'd6, 8'd2, 8'd3, 8'd5, 8'd7, 8'd9, 8'd0);
      endcase
      // The extreme settings are slow and rarely decode, so they get one frame or noise burst.
      nframes = (phase % 8 == 5 || phase % 8 == 7) ? 1 : $urandom_range(2, 5);
      phase++;
      repeat (nframes) begin
        if (samples_sent < 700) begin
          pick = $urandom_range(0, 9);
          if (pick < 3) begin
            send_frame(1'b1);
          end else if (pick < 8) begin
            send_frame(1'b0);
          end else begin
            send_noise();
          end
        end
      end
    end

    // Closing stretch without stalls on either side.
    calm = 1'b1;
    send_noise();

    settle();
    repeat (3) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin : watchdog
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/ipwd_pkg.sv
hw/rtl/ipwd_in_if.sv
hw/rtl/ipwd_out_if.sv
hw/rtl/ipwd_classify.sv
hw/rtl/ipwd_out_buf.sv
hw/rtl/ir_pulse_width_command_decoder_top.sv
verif/ipwd_code_checker.sv
verif/testbench.sv
